>>> sv/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/svtlv_pkg.sv
// ----------------------------------------------------------------------------
// svtlv_pkg
// Shared constants and types of the sampled-values parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svtlv_pkg;

   localparam int MaxAsdu = 8;
   localparam int AcntW   = 4;

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_HEADER = 4'd1;
   localparam logic [3:0] PH_OTAG   = 4'd2;
   localparam logic [3:0] PH_OLEN   = 4'd3;
   localparam logic [3:0] PH_NOASDU = 4'd4;
   localparam logic [3:0] PH_ITAG   = 4'd5;
   localparam logic [3:0] PH_ILEN   = 4'd6;
   localparam logic [3:0] PH_ICONT  = 4'd7;

   localparam logic [7:0] TAG_SAVPDU = 8'h60;
   localparam logic [7:0] TAG_NOASDU = 8'h80;
   localparam logic [7:0] TAG_SEQ    = 8'ha2;
   localparam logic [7:0] TAG_ASDU   = 8'h30;
   localparam logic [7:0] TAG_IMIN   = 8'h80;
   localparam logic [7:0] TAG_IMAX   = 8'h88;

   localparam logic [4:0] FID_APPID  = 5'd0;
   localparam logic [4:0] FID_LENGTH = 5'd1;
   localparam logic [4:0] FID_NOASDU = 5'd2;
   localparam logic [4:0] FID_AERR   = 5'd15;
   localparam logic [4:0] FID_FEND   = 5'd16;

   localparam logic [1:0] CSR_ID  = 2'd0;
   localparam logic [1:0] CSR_DS  = 2'd1;
   localparam logic [1:0] CSR_SMP = 2'd2;

   typedef struct packed {
      logic [4:0]  field_id;
      logic [2:0]  asdu_index;
      logic [7:0]  byte_offset;
      logic [63:0] field_value;
   } result_type;

   function automatic logic [4:0] inner_id(input logic [3:0] t);
      case (t)
         4'd0: inner_id = 5'd3;
         4'd1: inner_id = 5'd5;
         4'd2: inner_id = 5'd7;
         4'd3: inner_id = 5'd8;
         4'd4: inner_id = 5'd9;
         4'd5: inner_id = 5'd10;
         4'd6: inner_id = 5'd11;
         4'd7: inner_id = 5'd12;
         default: inner_id = 5'd14;
      endcase
   endfunction

   function automatic logic [3:0] inner_size(input logic [3:0] t);
      case (t)
         4'd2: inner_size = 4'd2;
         4'd3: inner_size = 4'd4;
         4'd4: inner_size = 4'd8;
         4'd5: inner_size = 4'd1;
         4'd6: inner_size = 4'd2;
         4'd8: inner_size = 4'd1;
         default: inner_size = 4'd0;
      endcase
   endfunction

endpackage

>>> sv/svtlv_step.sv
// ----------------------------------------------------------------------------
// svtlv_step
// Parser state and per-word decode; produces up to two results per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svtlv_step import svtlv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [7:0]  data_byte,
   input  logic        frame_start,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output logic [1:0]  num_res,
   output result_type  res0,
   output result_type  res1
);

   logic [7:0]  max_id_ff, max_ds_ff, max_smp_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] fcount_ff, fcount_in, flen_ff, flen_in;
   logic [7:0]  tag_ff, tag_in, flength_ff, flength_in, fpos_ff, fpos_in;
   logic [7:0]  arem_ff, arem_in;
   logic [AcntW-1:0] acnt_ff, acnt_in;
   logic        skip_ff, skip_in;
   logic [63:0] acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_id_ff  <= 8'd34;
         max_ds_ff  <= 8'd130;
         max_smp_ff <= 8'd64;
      end else if (csr_write) begin
         if (csr_index == CSR_ID) max_id_ff <= csr_data;
         if (csr_index == CSR_DS) max_ds_ff <= csr_data;
         if (csr_index == CSR_SMP) max_smp_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fcount_ff <= '0;
         flen_ff <= '0;
         tag_ff <= '0;
         flength_ff <= '0;
         fpos_ff <= '0;
         arem_ff <= '0;
         acnt_ff <= '0;
         skip_ff <= 1'b0;
         acc_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         fcount_ff <= fcount_in;
         flen_ff <= flen_in;
         tag_ff <= tag_in;
         flength_ff <= flength_in;
         fpos_ff <= fpos_in;
         arem_ff <= arem_in;
         acnt_ff <= acnt_in;
         skip_ff <= skip_in;
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      logic [3:0]  ph;
      logic [15:0] pos, fc, fl;
      logic [63:0] acc;
      logic [7:0]  ar, t8, lim, fp;
      logic [3:0]  t, sz;
      logic [AcntW-1:0] ac;
      logic        sk, bnd;
      logic [2:0]  ai;
      result_type  r;
      r = '0;
      ph = phase_ff; fc = fcount_ff; fl = flen_ff; acc = acc_ff;
      ar = arem_ff; ac = acnt_ff; sk = skip_ff;
      tag_in = tag_ff; flength_in = flength_ff; fpos_in = fpos_ff;
      num_res = 2'd0; res0 = '0; res1 = '0; bnd = 1'b0;
      t8 = tag_ff - TAG_IMIN;
      t = t8[3:0];
      sz = inner_size(t);
      lim = 8'd255; fp = 8'd0;
      if (frame_start) begin
         ph = PH_HEADER; fc = '0; fl = '0; ac = '0; sk = 1'b0; ar = '0; acc = '0;
      end
      pos = fc;
      ai = ac[2:0];
      if (ph != PH_IDLE) begin
         if (fc != 16'hffff) fc = fc + 16'd1;
         case (ph)
            PH_HEADER: begin
               if (pos == 16'd0 || pos == 16'd2) begin
                  acc = {56'd0, data_byte};
               end else if (pos == 16'd1) begin
                  acc = {48'd0, acc[7:0], data_byte};
                  r = '0; r.field_id = FID_APPID; r.field_value = acc;
                  res0 = r; num_res = 2'd1;
               end else if (pos == 16'd3) begin
                  fl = {acc[7:0], data_byte};
                  r = '0; r.field_id = FID_LENGTH; r.field_value = {48'd0, fl};
                  res0 = r; num_res = 2'd1;
               end else if (pos >= 16'd7) begin
                  bnd = 1'b1;
               end
            end
            PH_OTAG: begin
               if (data_byte == TAG_SAVPDU || data_byte == TAG_NOASDU ||
                   data_byte == TAG_SEQ ||
                   (data_byte == TAG_ASDU && ac < AcntW'(MaxAsdu))) begin
                  tag_in = data_byte; ph = PH_OLEN;
               end else begin
                  r = '0; r.field_id = FID_FEND; r.field_value = 64'd1;
                  res0 = r; num_res = 2'd1; ph = PH_IDLE;
               end
            end
            PH_OLEN: begin
               if (tag_ff == TAG_NOASDU) begin
                  flength_in = data_byte; fpos_in = '0; acc = '0;
                  if (data_byte == 8'd0) begin
                     r = '0; r.field_id = FID_NOASDU;
                     res0 = r; num_res = 2'd1; bnd = 1'b1;
                  end else ph = PH_NOASDU;
               end else if (tag_ff == TAG_ASDU) begin
                  ar = data_byte; sk = 1'b0;
                  if (data_byte == 8'd0) begin
                     ac = ac + AcntW'(1); bnd = 1'b1;
                  end else ph = PH_ITAG;
               end else bnd = 1'b1;
            end
            PH_NOASDU: begin
               if (fpos_ff == 8'd0) acc = {56'd0, data_byte};
               fpos_in = fpos_ff + 8'd1;
               if (fpos_in >= flength_ff) begin
                  r = '0; r.field_id = FID_NOASDU; r.field_value = acc;
                  res0 = r; num_res = 2'd1; bnd = 1'b1;
               end
            end
            default: begin
               if (ar != 8'd0) ar = ar - 8'd1;
               if (!sk) begin
                  if (ph == PH_ITAG) begin
                     if (data_byte < TAG_IMIN || data_byte > TAG_IMAX || ar == 8'd0) begin
                        r = '0; r.field_id = FID_AERR; r.asdu_index = ai;
                        r.field_value = 64'd1; res0 = r; num_res = 2'd1; sk = 1'b1;
                     end else begin
                        tag_in = data_byte; ph = PH_ILEN;
                     end
                  end else if (ph == PH_ILEN) begin
                     if (t8 == 8'd0) lim = max_id_ff;
                     else if (t8 == 8'd1) lim = max_ds_ff;
                     else if (t8 == 8'd7) lim = max_smp_ff;
                     if (t8 > 8'd8 || data_byte > ar || data_byte > lim) begin
                        r = '0; r.field_id = FID_AERR; r.asdu_index = ai;
                        r.field_value = 64'd1; res0 = r; num_res = 2'd1; sk = 1'b1;
                     end else begin
                        flength_in = data_byte; fpos_in = '0; acc = '0;
                        if (sz == 4'd0) begin
                           r = '0; r.field_id = inner_id(t) + 5'd1; r.asdu_index = ai;
                           r.field_value = {56'd0, data_byte};
                           res0 = r; num_res = 2'd1;
                        end
                        if (data_byte == 8'd0) begin
                           if (sz != 4'd0) begin
                              r = '0; r.field_id = inner_id(t); r.asdu_index = ai;
                              res0 = r; num_res = 2'd1;
                           end
                           ph = PH_ITAG;
                        end else ph = PH_ICONT;
                     end
                  end else begin
                     if (t8 > 8'd8) begin
                        r = '0; r.field_id = FID_AERR; r.asdu_index = ai;
                        r.field_value = 64'd1; res0 = r; num_res = 2'd1; sk = 1'b1;
                     end else begin
                        if (sz == 4'd0) begin
                           r = '0; r.field_id = inner_id(t); r.asdu_index = ai;
                           r.byte_offset = fpos_ff; r.field_value = {56'd0, data_byte};
                           res0 = r; num_res = 2'd1;
                        end else if (fpos_ff < {4'd0, sz}) begin
                           acc = {acc[55:0], data_byte};
                        end
                        fp = fpos_ff + 8'd1;
                        fpos_in = fp;
                        if (fp >= flength_ff) begin
                           if (sz != 4'd0) begin
                              r = '0; r.field_id = inner_id(t); r.asdu_index = ai;
                              r.field_value = acc; res0 = r; num_res = 2'd1;
                           end
                           ph = PH_ITAG;
                        end
                     end
                  end
               end
               if (ar == 8'd0) begin
                  ac = ac + AcntW'(1); sk = 1'b0; bnd = 1'b1;
               end
            end
         endcase
         if (bnd) begin
            if (fc >= fl) begin
               r = '0; r.field_id = FID_FEND;
               if (num_res == 2'd0) begin
                  res0 = r; num_res = 2'd1;
               end else begin
                  res1 = r; num_res = 2'd2;
               end
               ph = PH_IDLE;
            end else ph = PH_OTAG;
         end
      end
      phase_in = ph; fcount_in = fc; flen_in = fl; acc_in = acc;
      arem_in = ar; acnt_in = ac; skip_in = sk;
   end

endmodule

>>> sv/svtlv_out.sv
// ----------------------------------------------------------------------------
// svtlv_out
// Result queue: holds up to two words per input word and drains one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svtlv_out import svtlv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [1:0]  num_res,
   input  result_type  res0,
   input  result_type  res1,
   output logic        room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_res,
   output logic        rsp_last
);

   // 4-entry ring of results with their last flags
   result_type  q_ff [4];
   logic [3:0]  lastq_ff;
   logic [1:0]  rd_ff, wr_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;

   assign pop = rsp_valid && !rsp_stall;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_res = q_ff[rd_ff];
   assign rsp_last = lastq_ff[rd_ff];
   // room for two more even if nothing drains
   assign room = cnt_ff <= 3'd2;
   assign cnt_in = cnt_ff + (push ? {1'b0, num_res} : 3'd0) - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (pop) rd_ff <= rd_ff + 2'd1;
         if (push) wr_ff <= wr_ff + num_res;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && num_res != 2'd0) begin
         q_ff[wr_ff] <= res0;
         lastq_ff[wr_ff] <= (num_res == 2'd1);
         if (num_res == 2'd2) begin
            q_ff[wr_ff + 2'd1] <= res1;
            lastq_ff[wr_ff + 2'd1] <= 1'b1;
         end
      end
   end

   `ASSERT_CLK(a_no_overflow, clock, reset, cnt_ff <= 3'd4, "result queue overflow")
   `ASSERT_CLK(a_push_room, clock, reset, push |-> room, "push without room")
   `ASSERT_CLK(a_cnt_step, clock, reset, (!push && !pop) |=> $stable(cnt_ff), "count drift")

endmodule

>>> sv/sampled_values_tlv_parser_core.sv
// ----------------------------------------------------------------------------
// sampled_values_tlv_parser_core
// Sampled-values payload parser, one byte per word.
// ----------------------------------------------------------------------------
// Results of an accepted byte are written into the registered result queue.
// One byte is accepted per cycle while the result queue has room for two
// more results; otherwise req_stall holds the input.
// Reset: synchronous, active high; state registers go to defaults, parser idle.
`timescale 1ns / 1ps

module sampled_values_tlv_parser_core import svtlv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_field_id,
   output logic [2:0]  rsp_asdu_index,
   output logic [7:0]  rsp_byte_offset,
   output logic [63:0] rsp_field_value,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic        room, advance;
   logic [1:0]  num_res;
   result_type  res0, res1, rsp_res;

   assign req_stall = !room;
   assign advance = req_valid && room;

   svtlv_step u_step (
      .clock, .reset, .advance,
      .data_byte(req_data_byte), .frame_start(req_frame_start),
      .csr_write, .csr_index, .csr_data,
      .num_res, .res0, .res1
   );

   svtlv_out u_out (
      .clock, .reset, .push(advance), .num_res, .res0, .res1,
      .room, .rsp_valid, .rsp_stall, .rsp_res, .rsp_last
   );

   assign rsp_field_id = rsp_res.field_id;
   assign rsp_asdu_index = rsp_res.asdu_index;
   assign rsp_byte_offset = rsp_res.byte_offset;
   assign rsp_field_value = rsp_res.field_value;

endmodule
